// ===== rtl/clock_with_keypad_time_entry_core_macros.svh =====
// Assertion macros shared by the clock core RTL.
// Included by the core module, which carries the concurrent checks; needs no package.
`ifndef CLOCK_WITH_KEYPAD_TIME_ENTRY_CORE_MACROS_SVH
`define CLOCK_WITH_KEYPAD_TIME_ENTRY_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CLKKP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CLKKP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/clkkp_pkg.sv =====
// Types, constants and helpers for the keypad clock core.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package clkkp_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_ENTER  = 8'd0;
    localparam logic [7:0] REG_EDIT   = 8'd1;
    localparam logic [7:0] REG_ESCAPE = 8'd2;
    localparam logic [7:0] REG_DELETE = 8'd3;

    // Key code reset values
    localparam logic [7:0] RST_ENTER  = 8'd13;
    localparam logic [7:0] RST_EDIT   = 8'd69;
    localparam logic [7:0] RST_ESCAPE = 8'd27;
    localparam logic [7:0] RST_DELETE = 8'd8;

    // Request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    // Modes
    localparam logic MODE_VIEW = 1'b0;
    localparam logic MODE_EDIT = 1'b1;

    // ASCII digit bounds and per-position digit limits
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [3:0] LIM_H10     = 4'd2;
    localparam logic [3:0] LIM_H1_LOW  = 4'd9;
    localparam logic [3:0] LIM_H1_HIGH = 4'd3;
    localparam logic [3:0] LIM_TENS    = 4'd5;
    localparam logic [3:0] LIM_UNITS   = 4'd9;

    // Entry positions
    localparam logic [2:0] POS_FIRST = 3'd1;
    localparam logic [2:0] POS_LAST  = 3'd6;
    localparam logic [2:0] POS_DONE  = 3'd7;

    // Counter wrap points (last value before wrap)
    localparam logic [5:0] SEC_MAX  = 6'd59;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;

    typedef struct packed {
        logic       req_type;
        logic [7:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic       edit_mode;
        logic [4:0] hours_now;
        logic [5:0] minutes_now;
        logic [5:0] seconds_now;
        logic [2:0] entry_position;
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       clear_display;
        logic       delete_last;
        logic       refresh_display;
    } t_out_item;

    typedef struct packed {
        logic [7:0] idx;
        logic [7:0] wdata;
    } t_cfg_item;

    typedef struct packed {
        logic [7:0] enter_key;
        logic [7:0] edit_key;
        logic [7:0] escape_key;
        logic [7:0] delete_key;
    } t_keys;

    typedef struct packed {
        logic            mode;
        logic [4:0]      hours;
        logic [5:0]      minutes;
        logic [5:0]      seconds;
        logic [2:0]      pos;
        logic [5:0][3:0] digits;
    } t_state;

    // Two decimal digits to a binary value: hi*10 + lo
    function automatic logic [6:0] dec_pair(input logic [3:0] hi, input logic [3:0] lo);
        logic [6:0] hi_w;
        hi_w = {3'b000, hi};
        return (hi_w << 3) + (hi_w << 1) + {3'b000, lo};
    endfunction

endpackage

// ===== rtl/clkkp_in_if.sv =====
// Valid/ready channel carrying request items into the clock core.
// Depends on clkkp_pkg for the payload type.
`timescale 1ns / 1ps

interface clkkp_in_if import clkkp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/clkkp_out_if.sv =====
// Valid/ready channel carrying result items out of the clock core.
// Depends on clkkp_pkg for the payload type.
`timescale 1ns / 1ps

interface clkkp_out_if import clkkp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/clkkp_cfg_if.sv =====
// Valid/ready write channel for the key code registers.
// Depends on clkkp_pkg for the payload type.
`timescale 1ns / 1ps

interface clkkp_cfg_if import clkkp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/clkkp_step.sv =====
// Next-state and result logic for one request item of the clock core.
// Purely combinational; depends on clkkp_pkg.
`timescale 1ns / 1ps

module clkkp_step import clkkp_pkg::*; (
    input  t_state    i_state,
    input  t_keys     i_keys,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    t_state     n_st;
    t_out_item  res;
    logic [3:0] lim;
    logic [7:0] key_hi;
    logic       digit_ok;
    logic [2:0] wr_idx;

    // Upper digit bound for the current entry position
    always_comb begin
        case (i_state.pos)
            3'd1:    lim = LIM_H10;
            3'd2:    lim = (i_state.digits[0] < LIM_H10) ? LIM_H1_LOW : LIM_H1_HIGH;
            3'd3:    lim = LIM_TENS;
            3'd4:    lim = LIM_UNITS;
            3'd5:    lim = LIM_TENS;
            3'd6:    lim = LIM_UNITS;
            default: lim = 4'd0;
        endcase
    end

    assign key_hi   = CH_ZERO + {4'b0000, lim};
    assign digit_ok = (i_state.mode == MODE_EDIT)
                   && (i_state.pos >= POS_FIRST) && (i_state.pos <= POS_LAST)
                   && (i_item.key_code >= CH_ZERO) && (i_item.key_code <= key_hi);
    assign wr_idx   = i_state.pos - 3'd1;

    always_comb begin
        n_st = i_state;
        res  = '0;
        if (i_item.req_type == REQ_TICK) begin
            // Refresh in view mode, then advance the time
            res.refresh_display = (i_state.mode == MODE_VIEW);
            if (i_state.seconds >= SEC_MAX) begin
                n_st.seconds = '0;
                if (i_state.minutes >= MIN_MAX) begin
                    n_st.minutes = '0;
                    n_st.hours   = (i_state.hours >= HOUR_MAX) ? '0 : i_state.hours + 5'd1;
                end else begin
                    n_st.minutes = i_state.minutes + 6'd1;
                end
            end else begin
                n_st.seconds = i_state.seconds + 6'd1;
            end
        end else begin
            // Store and echo an accepted digit
            if (digit_ok) begin
                for (int i = 0; i < 6; i++) begin
                    if (wr_idx == 3'(i)) begin
                        n_st.digits[i] = i_item.key_code[3:0];
                    end
                end
                n_st.pos       = i_state.pos + 3'd1;
                res.echo_valid = 1'b1;
                res.echo_char  = i_item.key_code;
            end
            // Load the entered time once all six digits are in
            if ((i_item.key_code == i_keys.enter_key) && (n_st.pos == POS_DONE)) begin
                n_st.mode    = MODE_VIEW;
                n_st.pos     = POS_FIRST;
                n_st.hours   = 5'(dec_pair(n_st.digits[0], n_st.digits[1]));
                n_st.minutes = 6'(dec_pair(n_st.digits[2], n_st.digits[3]));
                n_st.seconds = 6'(dec_pair(n_st.digits[4], n_st.digits[5]));
            end
            // Edit, else escape, else delete
            if ((i_item.key_code == i_keys.edit_key) && (n_st.mode == MODE_VIEW)) begin
                n_st.mode         = MODE_EDIT;
                n_st.pos          = POS_FIRST;
                res.clear_display = 1'b1;
            end else if (i_item.key_code == i_keys.escape_key) begin
                n_st.mode = MODE_VIEW;
                n_st.pos  = POS_FIRST;
            end else if ((i_item.key_code == i_keys.delete_key) && (n_st.mode == MODE_EDIT)) begin
                if (n_st.pos > POS_FIRST) begin
                    n_st.pos        = n_st.pos - 3'd1;
                    res.delete_last = 1'b1;
                end
            end
        end
        res.edit_mode      = n_st.mode;
        res.hours_now      = n_st.hours;
        res.minutes_now    = n_st.minutes;
        res.seconds_now    = n_st.seconds;
        res.entry_position = n_st.pos;
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

// ===== rtl/clock_with_keypad_time_entry_core.sv =====
// Keypad clock core: time-of-day counter with keypad time entry.
// Usage:
//   i_item   request items: req_type 0 is a one-second tick, 1 is a key press
//            with its ASCII key_code.
//   o_result one result item per request: mode, time, entry position and
//            the display actions (echo, clear, delete, refresh).
//   i_cfg    writes the enter, edit, escape and delete key codes (index 0..3);
//            always ready, other indexes are ignored. Write only while idle.
// Timing:
//   An accepted item's result is registered into the output stage. One item is
//   accepted per cycle while i_item.ready is high; the whole state update is a
//   single pass through the step logic into the state and result registers.
//   A two-entry output stage (result register plus skid register) keeps
//   i_item.ready high while one finished result waits; ready drops only when
//   both entries are full, i.e. when a result is held by a stalled receiver
//   at the edge where a further item is accepted.
// Reset (i_rst_n low, synchronous): view mode, time 00:00:00, entry
// position 1, digits zero, key codes 13/69/27/8, output stage empty.
`timescale 1ns / 1ps
`include "clock_with_keypad_time_entry_core_macros.svh"

module clock_with_keypad_time_entry_core import clkkp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    clkkp_in_if.sink     i_item,
    clkkp_out_if.source  o_result,
    clkkp_cfg_if.sink    i_cfg
);

    t_state    r_state;
    t_state    n_state;
    t_keys     r_keys;
    t_out_item n_result;
    t_out_item r_out;
    t_out_item r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    logic      in_fire;
    logic      out_fire;

    assign i_item.ready    = !r_skid_valid;
    assign i_cfg.ready     = 1'b1;
    assign o_result.valid  = r_out_valid;
    assign o_result.data   = r_out;

    assign in_fire  = i_item.valid && !r_skid_valid;
    assign out_fire = r_out_valid && o_result.ready;

    clkkp_step u_step (
        .i_state  (r_state),
        .i_keys   (r_keys),
        .i_item   (i_item.data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Key code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys.enter_key  <= RST_ENTER;
            r_keys.edit_key   <= RST_EDIT;
            r_keys.escape_key <= RST_ESCAPE;
            r_keys.delete_key <= RST_DELETE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.idx)
                REG_ENTER:  r_keys.enter_key  <= i_cfg.data.wdata;
                REG_EDIT:   r_keys.edit_key   <= i_cfg.data.wdata;
                REG_ESCAPE: r_keys.escape_key <= i_cfg.data.wdata;
                REG_DELETE: r_keys.delete_key <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    // Clock and edit state, advanced on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode    <= MODE_VIEW;
            r_state.hours   <= '0;
            r_state.minutes <= '0;
            r_state.seconds <= '0;
            r_state.pos     <= POS_FIRST;
            r_state.digits  <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Output stage control: result register backed by a skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    // Output stage payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    `CLKKP_ASSERT_NOW(a_skid_implies_out, i_clk, i_rst_n,
        r_skid_valid, r_out_valid, "skid entry held without a result in the output register")
    `CLKKP_ASSERT_NOW(a_view_pos_first, i_clk, i_rst_n,
        r_state.mode == MODE_VIEW, r_state.pos == POS_FIRST,
        "entry position not reset in view mode")
    `CLKKP_ASSERT_NOW(a_time_range, i_clk, i_rst_n, 1'b1,
        (r_state.seconds <= SEC_MAX) && (r_state.minutes <= MIN_MAX)
            && (r_state.hours <= HOUR_MAX),
        "time counter out of range")
    `CLKKP_ASSERT_NOW(a_pos_nonzero, i_clk, i_rst_n,
        1'b1, r_state.pos != 3'd0, "entry position fell to zero")
    `CLKKP_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n,
        in_fire, r_out_valid, "accepted item left no result")

endmodule

// ===== dv/tb_clock_with_keypad_time_entry_core.sv =====
// Self-checking testbench for the keypad clock core: ticks and key items go in,
// each result is compared against an in-bench time/edit predictor or a pinned value.
// Depends on clkkp_pkg and the clkkp_in_if, clkkp_out_if and clkkp_cfg_if interfaces.
`timescale 1ns / 1ps

module tb_clock_with_keypad_time_entry_core;
    import clkkp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 200;
    localparam int PHASE_ITEMS  = 105;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic      pinned;
        t_in_item  item;
        t_out_item want;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    clkkp_in_if  in_ch ();
    clkkp_out_if out_ch ();
    clkkp_cfg_if cfg_ch ();

    clock_with_keypad_time_entry_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch),
        .i_cfg    (cfg_ch)
    );

    // Predicted clock and edit state
    logic       tod_mode;
    logic [4:0] tod_hours;
    logic [5:0] tod_minutes;
    logic [5:0] tod_seconds;
    logic [2:0] entry_pos;
    logic [3:0] entry_digits [6];
    t_keys      key_codes;

    t_out_item  pending_readouts [$];
    t_in_item   keypad_plan [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    logic       sender_rush = 1'b0;
    logic       receiver_rush = 1'b0;
    logic       hold_off_pending = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Highest digit allowed at an entry position
    function automatic logic [3:0] digit_ceiling(input logic [2:0] pos,
                                                 input logic [3:0] first_digit);
        case (pos)
            3'd1: return LIM_H10;
            3'd2: return (first_digit < LIM_H10) ? LIM_H1_LOW : LIM_H1_HIGH;
            3'd3, 3'd5: return LIM_TENS;
            3'd4, 3'd6: return LIM_UNITS;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] digit_key(input logic [3:0] d);
        return CH_ZERO + {4'd0, d};
    endfunction

    // Apply one item to the predicted state and return the readout it causes
    function automatic t_out_item next_readout(input t_in_item it);
        t_out_item  r;
        logic [7:0] value;
        int         loaded;
        r = '0;
        if (it.req_type == REQ_TICK) begin
            r.refresh_display = (tod_mode == MODE_VIEW);
            if (tod_seconds >= SEC_MAX) begin
                tod_seconds = 6'd0;
                if (tod_minutes >= MIN_MAX) begin
                    tod_minutes = 6'd0;
                    tod_hours = (tod_hours >= HOUR_MAX) ? 5'd0 : tod_hours + 5'd1;
                end else begin
                    tod_minutes = tod_minutes + 6'd1;
                end
            end else begin
                tod_seconds = tod_seconds + 6'd1;
            end
        end else begin
            // digit first
            if (tod_mode == MODE_EDIT && it.key_code >= CH_ZERO
                    && entry_pos >= POS_FIRST && entry_pos <= POS_LAST) begin
                value = it.key_code - CH_ZERO;
                if (value <= {4'd0, digit_ceiling(entry_pos, entry_digits[0])}) begin
                    entry_digits[entry_pos - 3'd1] = value[3:0];
                    entry_pos = entry_pos + 3'd1;
                    r.echo_valid = 1'b1;
                    r.echo_char = it.key_code;
                end
            end
            // then enter, once all six digits are in
            if (it.key_code == key_codes.enter_key && entry_pos == POS_DONE) begin
                tod_mode = MODE_VIEW;
                entry_pos = POS_FIRST;
                loaded = entry_digits[0] * 10 + entry_digits[1];
                tod_hours = loaded[4:0];
                loaded = entry_digits[2] * 10 + entry_digits[3];
                tod_minutes = loaded[5:0];
                loaded = entry_digits[4] * 10 + entry_digits[5];
                tod_seconds = loaded[5:0];
            end
            // last edit, else escape, else delete
            if (it.key_code == key_codes.edit_key && tod_mode == MODE_VIEW) begin
                tod_mode = MODE_EDIT;
                entry_pos = POS_FIRST;
                r.clear_display = 1'b1;
            end else if (it.key_code == key_codes.escape_key) begin
                tod_mode = MODE_VIEW;
                entry_pos = POS_FIRST;
            end else if (it.key_code == key_codes.delete_key && tod_mode == MODE_EDIT) begin
                if (entry_pos > POS_FIRST && entry_pos <= POS_DONE) begin
                    entry_pos = entry_pos - 3'd1;
                    r.delete_last = 1'b1;
                end
            end
        end
        r.edit_mode = tod_mode;
        r.hours_now = tod_hours;
        r.minutes_now = tod_minutes;
        r.seconds_now = tod_seconds;
        r.entry_position = entry_pos;
        return r;
    endfunction

    function automatic t_out_item readout_of(input logic mode, input logic [4:0] h,
                                             input logic [5:0] m, input logic [5:0] s,
                                             input logic [2:0] pos, input logic clr,
                                             input logic refresh);
        t_out_item r;
        r = '0;
        r.edit_mode = mode;
        r.hours_now = h;
        r.minutes_now = m;
        r.seconds_now = s;
        r.entry_position = pos;
        r.clear_display = clr;
        r.refresh_display = refresh;
        return r;
    endfunction

    function automatic t_script_row as_row(input logic req, input logic [7:0] code);
        t_script_row row;
        row = '0;
        row.item.req_type = req;
        row.item.key_code = code;
        return row;
    endfunction

    function automatic t_script_row pin(input t_script_row row, input t_out_item want);
        t_script_row r;
        r = row;
        r.pinned = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic string show(input t_out_item r);
        return $sformatf("mode %0b %02d:%02d:%02d pos %0d echo %0b/%h clr %0b del %0b ref %0b",
                         r.edit_mode, r.hours_now, r.minutes_now, r.seconds_now,
                         r.entry_position, r.echo_valid, r.echo_char, r.clear_display,
                         r.delete_last, r.refresh_display);
    endfunction

    function automatic void plan_key(input logic [7:0] code);
        t_in_item it;
        it.req_type = REQ_KEY;
        it.key_code = code;
        keypad_plan.push_back(it);
    endfunction

    function automatic void plan_tick();
        t_in_item it;
        it.req_type = REQ_TICK;
        it.key_code = 8'($urandom_range(0, 255));
        keypad_plan.push_back(it);
    endfunction

    // Queue one burst of random stimulus; half of the bursts are time entries
    function automatic void plan_burst();
        logic [3:0] first;
        logic [3:0] ceiling;
        logic [3:0] d;
        logic [2:0] pos;
        t_in_item   it;
        int         pick;
        int         n;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            plan_key(key_codes.edit_key);
            first = 4'd0;
            for (pos = POS_FIRST; pos <= POS_LAST; pos++) begin
                ceiling = digit_ceiling(pos, first);
                n = $urandom_range(0, 15);
                if (n == 0)
                    plan_tick();
                else if (n == 1)
                    plan_key(8'($urandom_range(0, 255)));
                else if (n == 2 && ceiling < LIM_UNITS)
                    plan_key(digit_key(4'($urandom_range(ceiling + 1, 9))));
                d = ($urandom_range(0, 2) == 0) ? ceiling : 4'($urandom_range(0, ceiling));
                if (n == 3) begin
                    plan_key(digit_key(d));
                    plan_key(key_codes.delete_key);
                end
                plan_key(digit_key(d));
                if (pos == POS_FIRST)
                    first = d;
            end
            n = $urandom_range(0, 9);
            if (n == 0) begin
                plan_key(key_codes.escape_key);
            end else if (n == 1) begin
                plan_key(key_codes.delete_key);
                plan_key(key_codes.enter_key);
            end else begin
                plan_key(key_codes.enter_key);
            end
        end else if (pick < 7) begin
            n = $urandom_range(1, 70);
            repeat (n) plan_tick();
        end else if (pick < 9) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                it.req_type = 1'($urandom_range(0, 1));
                it.key_code = 8'($urandom_range(0, 255));
                keypad_plan.push_back(it);
            end
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0: plan_key(key_codes.edit_key);
                    1: plan_key(key_codes.escape_key);
                    2: plan_key(key_codes.delete_key);
                    3: plan_key(key_codes.enter_key);
                    4: plan_tick();
                    default: plan_key(digit_key(4'($urandom_range(0, 9))));
                endcase
            end
        end
    endfunction

    // Offer one item after a random gap; predict on acceptance
    task automatic send_item(input t_in_item it, input logic pinned, input t_out_item want);
        t_out_item predicted;
        int        gap;
        if ($urandom_range(0, 31) == 0)
            sender_rush = !sender_rush;
        gap = sender_rush ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = next_readout(it);
        pending_readouts.push_back(pinned ? want : predicted);
    endtask

    // Write all four key code registers back to back
    task automatic program_keys(input t_keys k);
        t_cfg_item writes [4];
        writes[0] = '{idx: REG_ENTER,  wdata: k.enter_key};
        writes[1] = '{idx: REG_EDIT,   wdata: k.edit_key};
        writes[2] = '{idx: REG_ESCAPE, wdata: k.escape_key};
        writes[3] = '{idx: REG_DELETE, wdata: k.delete_key};
        for (int i = 0; i < 4; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data <= writes[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        key_codes = k;
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Result receiver: random stalls, one long hold-off on request
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                receiver_rush = !receiver_rush;
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = receiver_rush ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        string     diff;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_readouts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: %s", $realtime, show(got));
            end else begin
                want = pending_readouts.pop_front();
                diff = "";
                if (got.edit_mode !== want.edit_mode) diff = {diff, " edit_mode"};
                if (got.hours_now !== want.hours_now) diff = {diff, " hours_now"};
                if (got.minutes_now !== want.minutes_now) diff = {diff, " minutes_now"};
                if (got.seconds_now !== want.seconds_now) diff = {diff, " seconds_now"};
                if (got.entry_position !== want.entry_position)
                    diff = {diff, " entry_position"};
                if (got.echo_valid !== want.echo_valid) diff = {diff, " echo_valid"};
                if (got.echo_char !== want.echo_char) diff = {diff, " echo_char"};
                if (got.clear_display !== want.clear_display) diff = {diff, " clear_display"};
                if (got.delete_last !== want.delete_last) diff = {diff, " delete_last"};
                if (got.refresh_display !== want.refresh_display)
                    diff = {diff, " refresh_display"};
                if (diff != "") begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("[%0t] mismatch in%s\n  expected %s\n  actual   %s",
                                 $realtime, diff, show(want), show(got));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence: reset, directed script, then random phases per key setting
    initial begin
        t_script_row script [$];
        t_keys       phase_keys [6];
        int          sent;

        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        tod_mode = MODE_VIEW;
        tod_hours = 5'd0;
        tod_minutes = 6'd0;
        tod_seconds = 6'd0;
        entry_pos = POS_FIRST;
        foreach (entry_digits[i]) entry_digits[i] = 4'd0;
        key_codes = '{enter_key: RST_ENTER, edit_key: RST_EDIT,
                      escape_key: RST_ESCAPE, delete_key: RST_DELETE};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values, full entry of 23:59:59, wrap, edge keys
        script = '{
            pin(as_row(REQ_TICK, 8'hFF),
                readout_of(MODE_VIEW, 5'd0, 6'd0, 6'd1, POS_FIRST, 1'b0, 1'b1)),
            pin(as_row(REQ_KEY, RST_EDIT),
                readout_of(MODE_EDIT, 5'd0, 6'd0, 6'd1, POS_FIRST, 1'b1, 1'b0)),
            as_row(REQ_KEY, digit_key(4'd3)),
            as_row(REQ_KEY, digit_key(4'd2)),
            as_row(REQ_KEY, digit_key(4'd4)),
            as_row(REQ_KEY, digit_key(4'd3)),
            as_row(REQ_KEY, digit_key(4'd5)),
            as_row(REQ_KEY, digit_key(4'd9)),
            as_row(REQ_KEY, digit_key(4'd5)),
            as_row(REQ_KEY, digit_key(4'd9)),
            pin(as_row(REQ_KEY, RST_ENTER),
                readout_of(MODE_VIEW, 5'd23, 6'd59, 6'd59, POS_FIRST, 1'b0, 1'b0)),
            pin(as_row(REQ_TICK, 8'h00),
                readout_of(MODE_VIEW, 5'd0, 6'd0, 6'd0, POS_FIRST, 1'b0, 1'b1)),
            as_row(REQ_KEY, RST_EDIT),
            as_row(REQ_KEY, RST_DELETE),
            as_row(REQ_KEY, digit_key(4'd0)),
            as_row(REQ_KEY, digit_key(4'd9)),
            as_row(REQ_TICK, 8'h55),
            as_row(REQ_KEY, RST_DELETE),
            as_row(REQ_KEY, RST_ENTER),
            as_row(REQ_KEY, 8'h00),
            as_row(REQ_KEY, 8'hFF),
            as_row(REQ_KEY, RST_EDIT),
            as_row(REQ_KEY, RST_ESCAPE),
            as_row(REQ_KEY, RST_ESCAPE),
            as_row(REQ_KEY, RST_DELETE),
            as_row(REQ_KEY, RST_ENTER)
        };
        foreach (script[i])
            send_item(script[i].item, script[i].pinned, script[i].want);

        // Key settings: extremes, codes equal to digits, all codes equal,
        // two random sets, then back to the reset codes
        phase_keys[0] = '{enter_key: 8'h00, edit_key: 8'hFF,
                          escape_key: 8'h00, delete_key: 8'hFF};
        phase_keys[1] = '{enter_key: digit_key(4'd7), edit_key: digit_key(4'd0),
                          escape_key: digit_key(4'd9), delete_key: digit_key(4'd5)};
        phase_keys[2] = '{enter_key: 8'h41, edit_key: 8'h41,
                          escape_key: 8'h41, delete_key: 8'h41};
        phase_keys[3] = $urandom();
        phase_keys[4] = $urandom();
        phase_keys[5] = '{enter_key: RST_ENTER, edit_key: RST_EDIT,
                          escape_key: RST_ESCAPE, delete_key: RST_DELETE};

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            program_keys(phase_keys[ph]);
            if (ph == 1 || ph == 4)
                hold_off_pending = 1'b1;
            keypad_plan.delete();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (keypad_plan.size() == 0)
                    plan_burst();
                send_item(keypad_plan.pop_front(), 1'b0, '0);
                sent++;
            end
        end

        wait_idle();
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0 && pending_readouts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== clock_with_keypad_time_entry_core.f =====
+incdir+rtl
rtl/clkkp_pkg.sv
rtl/clkkp_in_if.sv
rtl/clkkp_out_if.sv
rtl/clkkp_cfg_if.sv
rtl/clkkp_step.sv
rtl/clock_with_keypad_time_entry_core.sv
dv/tb_clock_with_keypad_time_entry_core.sv
